### hdl/srrw_pkg.sv
// Package for the selective-repeat receive window.
// Holds request codes and handshake constants; no dependencies.
`default_nettype none

package srrw_pkg;

  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned ByteW    = 8;

  // Request type codes.
  localparam logic [ReqTypeW-1:0] ReqStart  = 2'd0;
  localparam logic [ReqTypeW-1:0] ReqData   = 2'd1;
  localparam logic [ReqTypeW-1:0] ReqFinish = 2'd2;

  // Handshake status codes.
  localparam logic [ByteW-1:0] HandshakeReq = 8'd205;
  localparam logic [ByteW-1:0] HandshakeAck = 8'd200;

  typedef struct packed {
    logic             send_reply;
    logic [ByteW-1:0] reply_byte;
    logic             accepted;
    logic             seq_error;
  } result_t;

endpackage

`default_nettype wire

### hdl/srrw_if.sv
// Channel interfaces for the selective-repeat receive window.
// Depends on srrw_pkg for field widths.
`default_nettype none

interface srrw_req_if;
  logic                           valid;
  logic                           ready;
  logic [srrw_pkg::ReqTypeW-1:0]  req_type;
  logic [srrw_pkg::ByteW-1:0]     head_byte;

  modport source (output valid, output req_type, output head_byte, input ready);
  modport sink   (input valid, input req_type, input head_byte, output ready);
endinterface

interface srrw_res_if;
  logic                        valid;
  logic                        ready;
  logic                        send_reply;
  logic [srrw_pkg::ByteW-1:0]  reply_byte;
  logic                        accepted;
  logic                        seq_error;

  modport source (output valid, output send_reply, output reply_byte,
                  output accepted, output seq_error, input ready);
  modport sink   (input valid, input send_reply, input reply_byte,
                  input accepted, input seq_error, output ready);
endinterface

`default_nettype wire

### hdl/selective_repeat_receive_window_top.sv
// Selective-repeat receive window: top level with sequencer and window logic.
// Depends on srrw_pkg and the channel interfaces in srrw_if.sv.
//
//   channel | dir | payload                                        | handshake
//   req_i   | in  | req_type, head_byte                            | valid/ready
//   res_o   | out | send_reply, reply_byte, accepted, seq_error    | valid/ready
//
// A request's result passes through the check and done states, and is presented
// once the output register is free; the next request is then taken in idle.
// An in-window datagram at the base then enters the slide state, which clears the run
// of set marks from the base and moves past them, at most min(WINDOW, SEQ_COUNT).
// Reset clears phase, window base and all marks at once.
// A result waits in the output register; a new request is taken meanwhile, and
// its own result waits in the sequencer until the output register frees up.
`default_nettype none

module selective_repeat_receive_window_top #(
  parameter int unsigned SEQ_COUNT = 20,
  parameter int unsigned WINDOW    = 10
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  srrw_req_if.sink        req_i,
  srrw_res_if.source      res_o
);

  localparam int unsigned IdxW  = $clog2(SEQ_COUNT);
  localparam int unsigned Limit = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
  localparam int unsigned CntW  = $clog2(Limit + 1);
  localparam int unsigned StepW = srrw_pkg::ByteW + 1;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StSlide,
    StDone
  } state_e;

  state_e                          state_q;
  logic                            phase_q;
  logic [IdxW-1:0]                 base_q;
  logic [SEQ_COUNT-1:0]            marks_q;
  logic [CntW-1:0]                 cnt_q;
  logic [srrw_pkg::ReqTypeW-1:0]   req_type_q;
  logic [srrw_pkg::ByteW-1:0]      head_q;
  srrw_pkg::result_t               res_d;
  srrw_pkg::result_t               res_q;
  srrw_pkg::result_t               out_q;
  logic                            out_valid_q;

  logic [srrw_pkg::ByteW-1:0]      head_dec;
  logic [IdxW-1:0]                 idx;
  logic [StepW-1:0]                step;
  logic                            in_range;
  logic                            in_window;
  logic [IdxW-1:0]                 base_inc;
  logic                            out_free;

  assign req_i.ready = (state_q == StIdle);

  assign res_o.valid      = out_valid_q;
  assign res_o.send_reply = out_q.send_reply;
  assign res_o.reply_byte = out_q.reply_byte;
  assign res_o.accepted   = out_q.accepted;
  assign res_o.seq_error  = out_q.seq_error;

  assign out_free = !out_valid_q || res_o.ready;

  // Shared distance unit: offset of the sequence index from the window base.
  always_comb begin
    head_dec  = head_q - 8'd1;
    idx       = IdxW'(head_dec);
    in_range  = (head_q != '0) && (head_q <= srrw_pkg::ByteW'(SEQ_COUNT));
    if (idx >= base_q) begin
      step = StepW'(idx) - StepW'(base_q);
    end else begin
      step = StepW'(idx) + StepW'(SEQ_COUNT) - StepW'(base_q);
    end
    in_window = (step < StepW'(WINDOW));
    base_inc  = (base_q == IdxW'(SEQ_COUNT - 1)) ? '0 : base_q + IdxW'(1);

    res_d = '0;
    if (req_type_q == srrw_pkg::ReqData) begin
      if (!phase_q) begin
        if (head_q == srrw_pkg::HandshakeReq) begin
          res_d.send_reply = 1'b1;
          res_d.reply_byte = srrw_pkg::HandshakeAck;
        end
      end else if (!in_range) begin
        res_d.seq_error = 1'b1;
      end else begin
        res_d.send_reply = 1'b1;
        res_d.reply_byte = head_q;
        res_d.accepted   = in_window;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= 1'b0;
      base_q      <= '0;
      marks_q     <= '0;
      cnt_q       <= '0;
      req_type_q  <= '0;
      head_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output register empties on a handshake unless a new result loads it.
      if (out_valid_q && res_o.ready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            req_type_q <= req_i.req_type;
            head_q     <= req_i.head_byte;
            state_q    <= StCheck;
          end
        end
        StCheck: begin
          res_q   <= res_d;
          state_q <= StDone;
          cnt_q   <= '0;
          priority if (req_type_q == srrw_pkg::ReqStart) begin
            phase_q <= 1'b0;
            base_q  <= '0;
            marks_q <= '0;
          end else if (req_type_q == srrw_pkg::ReqFinish) begin
            phase_q <= 1'b0;
          end else if (req_type_q == srrw_pkg::ReqData) begin
            if (!phase_q) begin
              if (head_q == srrw_pkg::HandshakeReq) begin
                phase_q <= 1'b1;
              end
            end else if (in_range && in_window) begin
              marks_q[idx] <= 1'b1;
              if (idx == base_q) begin
                state_q <= StSlide;
              end
            end
          end else begin
            // Unused request code: phase, base and marks stay as they are.
            phase_q <= phase_q;
          end
        end
        StSlide: begin
          if ((cnt_q == CntW'(Limit)) || !marks_q[base_q]) begin
            state_q <= StDone;
          end else begin
            marks_q[base_q] <= 1'b0;
            base_q          <= base_inc;
            cnt_q           <= cnt_q + CntW'(1);
          end
        end
        StDone: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_base_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q < IdxW'(SEQ_COUNT - 1) || base_q == IdxW'(SEQ_COUNT - 1))
    else $error("window base beyond sequence count");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.seq_error && (res_o.send_reply || res_o.accepted)))
    else $error("sequence error combined with an acknowledgment");

  a_accept_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.accepted) |-> res_o.send_reply)
    else $error("accepted datagram without reply");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck && req_type_q == srrw_pkg::ReqStart)
      |=> (marks_q == '0 && base_q == '0 && !phase_q))
    else $error("start request did not clear the window");

  a_slide_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSlide) |-> (cnt_q <= CntW'(Limit)))
    else $error("base advance exceeded its bound");

endmodule

`default_nettype wire
